>>> design/wph_pkg.sv
package wph_pkg;

  // default sizes
  localparam int unsigned BIN_BITS_DEF   = 16;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned MAX_DIM_DEF    = 4096;

  // fixed field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned WIN_W   = 13;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // request codes
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // pixel format codes
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_U16 = 2'd1;
  localparam logic [1:0] FMT_U12 = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COL_END   = 3'd4;

  // value limits
  localparam logic [VAL_W-1:0] CLAMP12   = 16'd4095;
  localparam logic [WIN_W-1:0] WIN_RESET = 13'd4096;

  // controller to datapath
  typedef struct packed {
    logic take_item;
    logic lookup;
    logic update;
    logic clear_total;
    logic wipe_step;
    logic emit;
  } wph_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             wipe_done;
    logic             out_free;
  } wph_status_t;

endpackage

>>> design/wph_ctrl.sv
module wph_ctrl
  import wph_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  wph_status_t status_i,
  output wph_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_CLEAR,
    S_EMIT
  } state_e;

  state_e state_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      unique case (state_q)
        S_INIT: begin
          if (status_i.wipe_done) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) state_q <= S_LOOKUP;
        end
        S_LOOKUP: begin
          if (status_i.req == REQ_CLEAR) state_q <= S_CLEAR;
          else state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          state_q <= S_EMIT;
        end
        S_CLEAR: begin
          if (status_i.wipe_done) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (status_i.out_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    in_ready_o        = (state_q == S_IDLE);
    cmd_o             = '0;
    cmd_o.take_item   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.lookup      = (state_q == S_LOOKUP);
    cmd_o.clear_total = (state_q == S_LOOKUP) && (status_i.req == REQ_CLEAR);
    cmd_o.update      = (state_q == S_UPDATE);
    cmd_o.wipe_step   = (state_q == S_INIT) || (state_q == S_CLEAR);
    cmd_o.emit        = (state_q == S_EMIT) && status_i.out_free;
  end

endmodule

>>> design/wph_datapath.sv
module wph_datapath
  import wph_pkg::*;
#(
  parameter int unsigned BinBits   = BIN_BITS_DEF,
  parameter int unsigned CountBits = COUNT_BITS_DEF,
  parameter int unsigned MaxDim    = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wph_cmd_t              cmd_i,
  output wph_status_t           status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [VAL_W-1:0]      pixel_value_i,
  input  logic [COORD_W-1:0]    pixel_row_i,
  input  logic [COORD_W-1:0]    pixel_col_i,
  input  logic [VAL_W-1:0]      bin_select_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_W-1:0]      bin_count_o,
  output logic [OUT_W-1:0]      pixel_total_o,
  output logic                  was_counted_o
);

  localparam int unsigned NumBins = 1 << BinBits;
  localparam logic [WIN_W-1:0] DimLimit = WIN_W'(MaxDim);

  // configuration registers
  logic [1:0]       fmt_q;
  logic [WIN_W-1:0] row_first_q, row_end_q, col_first_q, col_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_U8;
      row_first_q <= '0;
      row_end_q   <= WIN_RESET;
      col_first_q <= '0;
      col_end_q   <= WIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FORMAT:    fmt_q       <= cfg_data_i[1:0];
        REG_ROW_FIRST: row_first_q <= cfg_data_i;
        REG_ROW_END:   row_end_q   <= cfg_data_i;
        REG_COL_FIRST: col_first_q <= cfg_data_i;
        REG_COL_END:   col_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured request
  logic [REQ_W-1:0]   req_q;
  logic [VAL_W-1:0]   value_q;
  logic [COORD_W-1:0] row_q, col_q;
  logic [VAL_W-1:0]   sel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      req_q   <= req_type_i;
      value_q <= pixel_value_i;
      row_q   <= pixel_row_i;
      col_q   <= pixel_col_i;
      sel_q   <= bin_select_i;
    end
  end

  // window test and bin index
  logic [WIN_W-1:0]   row_w, col_w;
  logic               in_win, fmt_ok, hit;
  logic [VAL_W-1:0]   idx_raw;
  logic [BinBits-1:0] idx_bin, rd_addr;
  logic               sel_ok;

  always_comb begin
    row_w  = WIN_W'(row_q);
    col_w  = WIN_W'(col_q);
    in_win = (row_w < DimLimit) && (col_w < DimLimit) &&
             (row_w >= row_first_q) && (row_w < row_end_q) &&
             (col_w >= col_first_q) && (col_w < col_end_q);
    fmt_ok = (fmt_q == FMT_U8) || (fmt_q == FMT_U16) || (fmt_q == FMT_U12);
    hit    = (req_q == REQ_COUNT) && fmt_ok && in_win;
    case (fmt_q)
      FMT_U8:  idx_raw = {8'd0, value_q[7:0]};
      FMT_U12: idx_raw = (value_q > CLAMP12) ? CLAMP12 : value_q;
      default: idx_raw = value_q;
    endcase
    // saturate to the top bin
    idx_bin = ((idx_raw >> BinBits) != '0) ? '1 : idx_raw[BinBits-1:0];
    sel_ok  = ((sel_q >> BinBits) == '0);
    rd_addr = (req_q == REQ_READ) ? sel_q[BinBits-1:0] : idx_bin;
  end

  // bin memory, sweep counter and lookup registers
  logic [CountBits-1:0] bin_mem [NumBins];
  logic [CountBits-1:0] rdata_q, new_cnt;
  logic [BinBits-1:0]   addr_q, wipe_addr_q;
  logic                 hit_q, rd_ok_q;

  assign new_cnt = (rdata_q == '1) ? rdata_q : rdata_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wipe_step) begin
      bin_mem[wipe_addr_q] <= '0;
    end else if (cmd_i.update && hit_q) begin
      bin_mem[addr_q] <= new_cnt;
    end
    if (cmd_i.lookup) begin
      rdata_q <= bin_mem[rd_addr];
      addr_q  <= rd_addr;
      hit_q   <= hit;
      rd_ok_q <= (req_q == REQ_READ) && sel_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_addr_q <= '0;
    end else if (cmd_i.wipe_step) begin
      wipe_addr_q <= wipe_addr_q + 1'b1;
    end
  end

  // running total and pending result
  logic [CountBits-1:0] total_q, total_inc;
  logic [CountBits-1:0] res_count_q, res_total_q;
  logic                 res_counted_q;

  assign total_inc = (total_q == '1) ? total_q : total_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.clear_total) begin
      total_q <= '0;
    end else if (cmd_i.update && hit_q) begin
      total_q <= total_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_total) begin
      res_count_q   <= '0;
      res_total_q   <= '0;
      res_counted_q <= 1'b0;
    end else if (cmd_i.update) begin
      if (hit_q) begin
        res_count_q   <= new_cnt;
        res_total_q   <= total_inc;
        res_counted_q <= 1'b1;
      end else begin
        res_count_q   <= rd_ok_q ? rdata_q : '0;
        res_total_q   <= total_q;
        res_counted_q <= 1'b0;
      end
    end
  end

  // output register
  logic                 out_valid_q;
  logic [CountBits-1:0] out_count_q, out_total_q;
  logic                 out_counted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_count_q   <= res_count_q;
      out_total_q   <= res_total_q;
      out_counted_q <= res_counted_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bin_count_o   = OUT_W'(out_count_q);
  assign pixel_total_o = OUT_W'(out_total_q);
  assign was_counted_o = out_counted_q;

  // status back to the controller
  assign status_o.req       = req_q;
  assign status_o.wipe_done = (wipe_addr_q == '1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

>>> design/windowed_pixel_histogram.sv
// count and read requests: lookup, update, then emit, held while the output is busy;
// one request at a time; single bin memory port (registered read, then write back)
// clear request: one bin zeroed per cycle, then emit
// after reset the bins are swept to zero, no request taken
// reset is asynchronous active low; registers return to their default window
module windowed_pixel_histogram
  import wph_pkg::*;
#(
  parameter int unsigned BIN_BITS   = BIN_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [VAL_W-1:0]      pixel_value_i,
  input  logic [COORD_W-1:0]    pixel_row_i,
  input  logic [COORD_W-1:0]    pixel_col_i,
  input  logic [VAL_W-1:0]      bin_select_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_W-1:0]      bin_count_o,
  output logic [OUT_W-1:0]      pixel_total_o,
  output logic                  was_counted_o
);

  wph_cmd_t    cmd;
  wph_status_t status;

  // sequencer
  wph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // bins, window logic and result registers
  wph_datapath #(
    .BinBits   (BIN_BITS),
    .CountBits (COUNT_BITS),
    .MaxDim    (MAX_DIM)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .pixel_value_i (pixel_value_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .bin_select_i  (bin_select_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bin_count_o   (bin_count_o),
    .pixel_total_o (pixel_total_o),
    .was_counted_o (was_counted_o)
  );

  // no request taken while bins are being zeroed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.wipe_step)
    else $error("request accepted during bin sweep");

  // a held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten before it was taken");

  // a counted pixel leaves a nonzero bin and total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && was_counted_o) |-> (bin_count_o != '0 && pixel_total_o != '0))
    else $error("counted pixel with zero bin or total");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import wph_pkg::*;

  // codes the package leaves unnamed
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0]       FMT_UNUSED = 2'd3;

  localparam int unsigned NUM_BINS      = 1 << BIN_BITS_DEF;
  localparam int unsigned COORD_LIMIT   = MAX_DIM_DEF;
  localparam logic [OUT_W-1:0] COUNT_SAT = '1;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS   = 54;
  localparam int unsigned MAX_WAIT      = 6;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_CLEARS = 3;
  localparam int unsigned NUM_HOT       = 6;
  localparam int unsigned HOT_W         = $clog2(NUM_HOT);

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [VAL_W-1:0]   value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [VAL_W-1:0]   sel;
  } pixel_req_t;

  typedef struct {
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] pixel_total;
    logic             counted;
  } tally_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [REQ_W-1:0]      req_type_i    = '0;
  logic [VAL_W-1:0]      pixel_value_i = '0;
  logic [COORD_W-1:0]    pixel_row_i   = '0;
  logic [COORD_W-1:0]    pixel_col_i   = '0;
  logic [VAL_W-1:0]      bin_select_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [OUT_W-1:0]      bin_count_o;
  logic [OUT_W-1:0]      pixel_total_o;
  logic                  was_counted_o;

  windowed_pixel_histogram dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .pixel_value_i (pixel_value_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .bin_select_i  (bin_select_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bin_count_o   (bin_count_o),
    .pixel_total_o (pixel_total_o),
    .was_counted_o (was_counted_o)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // histogram image held by the bench
  logic [OUT_W-1:0] hist_bins [NUM_BINS];
  logic [OUT_W-1:0] tally_total = '0;
  logic [1:0]       fmt_cfg     = FMT_U8;
  logic [WIN_W-1:0] row_lo      = '0;
  logic [WIN_W-1:0] row_hi      = WIN_RESET;
  logic [WIN_W-1:0] col_lo      = '0;
  logic [WIN_W-1:0] col_hi      = WIN_RESET;

  pixel_req_t  request_queue [$];
  pixel_req_t  cur_req;
  tally_t      pending_results [$];
  bit          req_in_flight = 1'b0;
  bit          no_idle       = 1'b0;
  int unsigned send_gap      = 0;
  int unsigned recv_stall    = 0;
  int unsigned fail_count    = 0;

  function automatic void wipe_bins();
    foreach (hist_bins[k]) hist_bins[k] = '0;
    tally_total = '0;
  endfunction

  // bin a raw sample lands in for a given format
  function automatic logic [VAL_W-1:0] bin_of(logic [1:0] fmt, logic [VAL_W-1:0] v);
    if (fmt == FMT_U8) return {8'd0, v[7:0]};
    if (fmt == FMT_U12) return (v > CLAMP12) ? CLAMP12 : v;
    return v;
  endfunction

  function automatic logic [OUT_W-1:0] sat_bump(logic [OUT_W-1:0] v);
    return (v == COUNT_SAT) ? v : v + 1'b1;
  endfunction

  // apply one request to the histogram image, return the result it should give
  function automatic tally_t tally_request(pixel_req_t r);
    tally_t           res;
    logic [VAL_W-1:0] idx;
    logic             inside_win;
    res.bin_count = '0;
    res.counted   = 1'b0;
    inside_win = ({1'b0, r.row} >= row_lo) && ({1'b0, r.row} < row_hi) &&
                 ({1'b0, r.col} >= col_lo) && ({1'b0, r.col} < col_hi) &&
                 (r.row < COORD_LIMIT) && (r.col < COORD_LIMIT);
    case (r.req)
      REQ_COUNT: begin
        if (fmt_cfg != FMT_UNUSED && inside_win) begin
          idx = bin_of(fmt_cfg, r.value);
          if (idx >= NUM_BINS) idx = VAL_W'(NUM_BINS - 1);
          hist_bins[idx] = sat_bump(hist_bins[idx]);
          res.bin_count  = hist_bins[idx];
          tally_total    = sat_bump(tally_total);
          res.counted    = 1'b1;
        end
      end
      REQ_CLEAR: begin
        wipe_bins();
      end
      REQ_READ: begin
        if (r.sel < NUM_BINS) res.bin_count = hist_bins[r.sel];
      end
      default: begin
      end
    endcase
    res.pixel_total = tally_total;
    return res;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_in_flight = 1'b0;
      in_valid_i <= 1'b0;
    end else begin
      if (req_in_flight && in_ready_o) begin
        pending_results.push_back(tally_request(cur_req));
        req_in_flight = 1'b0;
        send_gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!req_in_flight) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_queue.size() > 0) begin
          cur_req = request_queue.pop_front();
          req_in_flight = 1'b1;
          req_type_i    <= cur_req.req;
          pixel_value_i <= cur_req.value;
          pixel_row_i   <= cur_req.row;
          pixel_col_i   <= cur_req.col;
          bin_select_i  <= cur_req.sel;
        end
      end
      in_valid_i <= req_in_flight;
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_monitor
    tally_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (bin_count_o !== want.bin_count) begin
            $error("bin_count mismatch: expected %0d, got %0d", want.bin_count, bin_count_o);
            fail_count++;
          end
          if (pixel_total_o !== want.pixel_total) begin
            $error("pixel_total mismatch: expected %0d, got %0d",
                   want.pixel_total, pixel_total_o);
            fail_count++;
          end
          if (was_counted_o !== want.counted) begin
            $error("was_counted mismatch: expected %0d, got %0d", want.counted, was_counted_o);
            fail_count++;
          end
        end
        recv_stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void queue_request(logic [REQ_W-1:0] req, logic [VAL_W-1:0] value,
                                        logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                        logic [VAL_W-1:0] sel);
    pixel_req_t r;
    r.req   = req;
    r.value = value;
    r.row   = row;
    r.col   = col;
    r.sel   = sel;
    request_queue.push_back(r);
  endfunction

  // mostly a coordinate inside [lo, hi), sometimes anywhere
  function automatic logic [COORD_W-1:0] pick_coord(logic [WIN_W-1:0] lo, logic [WIN_W-1:0] hi);
    if ($urandom_range(0, 4) != 0 && lo < hi && lo < COORD_LIMIT)
      return COORD_W'($urandom_range(lo, hi - 1));
    return COORD_W'($urandom_range(0, COORD_LIMIT - 1));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      REG_FORMAT:    fmt_cfg = data[1:0];
      REG_ROW_FIRST: row_lo  = data;
      REG_ROW_END:   row_hi  = data;
      REG_COL_FIRST: col_lo  = data;
      REG_COL_END:   col_hi  = data;
      default: begin
      end
    endcase
  endtask

  task automatic program_window(logic [1:0] fmt, logic [WIN_W-1:0] rf, logic [WIN_W-1:0] re,
                                logic [WIN_W-1:0] cf, logic [WIN_W-1:0] ce);
    write_reg(REG_FORMAT, CFG_DATA_W'(fmt));
    write_reg(REG_ROW_FIRST, rf);
    write_reg(REG_ROW_END, re);
    write_reg(REG_COL_FIRST, cf);
    write_reg(REG_COL_END, ce);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hold until every queued request has been answered, then let the block settle
  task automatic wait_drained();
    while (request_queue.size() > 0 || req_in_flight || pending_results.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // stimulus
  initial begin : stimulus
    logic [VAL_W-1:0] hot [NUM_HOT];
    logic [1:0]       fmt;
    logic [WIN_W-1:0] rf, re, cf, ce;
    logic [VAL_W-1:0] value;
    int unsigned      pick;
    int unsigned      clears_left;
    wipe_bins();
    clears_left = RANDOM_CLEARS;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block sweeps its bins after reset before it takes requests
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);

    // 8-bit format, full frame: low byte indexing, reads, unused code, clear
    program_window(FMT_U8, '0, WIN_RESET, '0, WIN_RESET);
    queue_request(REQ_COUNT, 16'h0000, 12'd0, 12'd0, 16'h0000);
    queue_request(REQ_COUNT, 16'hFFFF, 12'd4095, 12'd4095, 16'hFFFF);
    queue_request(REQ_COUNT, 16'h12FF, 12'd2048, 12'd1, 16'h0000);
    queue_request(REQ_READ, 16'h0000, 12'd0, 12'd0, 16'h00FF);
    queue_request(REQ_READ, 16'hFFFF, 12'd4095, 12'd4095, 16'hFFFF);
    queue_request(REQ_READ, 16'h0000, 12'd0, 12'd0, 16'h0000);
    queue_request(REQ_UNUSED, 16'hFFFF, 12'hFFF, 12'hFFF, 16'hFFFF);
    queue_request(REQ_CLEAR, 16'hA5A5, 12'h5A5, 12'hA5A, 16'h5A5A);
    queue_request(REQ_READ, 16'h0000, 12'd0, 12'd0, 16'h00FF);
    wait_drained();

    // 12-bit clamp and the window edges, both inclusive and exclusive
    program_window(FMT_U12, 13'd10, 13'd20, 13'd100, WIN_RESET);
    queue_request(REQ_COUNT, 16'd5000, 12'd10, 12'd100, 16'h0000);
    queue_request(REQ_COUNT, 16'd4095, 12'd19, 12'd4095, 16'h0000);
    queue_request(REQ_COUNT, 16'd1, 12'd20, 12'd100, 16'h0000);
    queue_request(REQ_COUNT, 16'd1, 12'd9, 12'd100, 16'h0000);
    queue_request(REQ_COUNT, 16'd1, 12'd15, 12'd99, 16'h0000);
    queue_request(REQ_READ, 16'h0000, 12'd0, 12'd0, 16'd4095);
    queue_request(REQ_READ, 16'h0000, 12'd0, 12'd0, 16'd5000);
    wait_drained();

    // 16-bit format, top bin, one-column window
    program_window(FMT_U16, '0, WIN_RESET, 13'd4095, WIN_RESET);
    queue_request(REQ_COUNT, 16'hFFFF, 12'd0, 12'd4095, 16'h0000);
    queue_request(REQ_READ, 16'h0000, 12'd0, 12'd0, 16'hFFFF);
    queue_request(REQ_COUNT, 16'h0000, 12'd0, 12'd4094, 16'h0000);
    wait_drained();

    // unused format code counts nothing
    program_window(FMT_UNUSED, '0, WIN_RESET, '0, WIN_RESET);
    queue_request(REQ_COUNT, 16'd7, 12'd1, 12'd1, 16'h0000);
    wait_drained();

    // inverted row window counts nothing
    program_window(FMT_U16, WIN_RESET, '0, '0, WIN_RESET);
    queue_request(REQ_COUNT, 16'd7, 12'd1, 12'd1, 16'h0000);
    queue_request(REQ_COUNT, 16'd7, 12'd4095, 12'd0, 16'h0000);
    queue_request(REQ_CLEAR, 16'h0000, 12'd0, 12'd0, 16'h0000);
    wait_drained();

    // random phases, each with its own format and window
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 15))
        0:           fmt = FMT_UNUSED;
        1, 2, 3, 4:  fmt = FMT_U8;
        5, 6, 7, 8:  fmt = FMT_U12;
        default:     fmt = FMT_U16;
      endcase
      case ($urandom_range(0, 5))
        0: begin
          rf = '0;
          re = WIN_RESET;
          cf = '0;
          ce = WIN_RESET;
        end
        1: begin
          re = WIN_W'($urandom_range(0, 2000));
          rf = WIN_W'($urandom_range(re, WIN_RESET));
          cf = '0;
          ce = WIN_W'($urandom_range(1, WIN_RESET));
        end
        default: begin
          rf = WIN_W'($urandom_range(0, 4000));
          re = WIN_W'($urandom_range(rf + 1, WIN_RESET));
          cf = WIN_W'($urandom_range(0, 4000));
          ce = WIN_W'($urandom_range(cf + 1, WIN_RESET));
        end
      endcase
      program_window(fmt, rf, re, cf, ce);
      // a few hot samples so bins collect more than one pixel
      foreach (hot[h]) hot[h] = VAL_W'($urandom_range(0, 16'hFFFF));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          value = $urandom_range(0, 1) ? hot[HOT_W'($urandom_range(0, NUM_HOT - 1))]
                                       : VAL_W'($urandom_range(0, 16'hFFFF));
          queue_request(REQ_COUNT, value, pick_coord(rf, re), pick_coord(cf, ce),
                        VAL_W'($urandom_range(0, 16'hFFFF)));
        end else if (pick < 93) begin
          value = $urandom_range(0, 2)
                  ? bin_of(fmt, hot[HOT_W'($urandom_range(0, NUM_HOT - 1))])
                  : VAL_W'($urandom_range(0, 16'hFFFF));
          queue_request(REQ_READ, VAL_W'($urandom_range(0, 16'hFFFF)),
                        COORD_W'($urandom_range(0, 12'hFFF)),
                        COORD_W'($urandom_range(0, 12'hFFF)), value);
        end else if (pick < 98 || clears_left == 0) begin
          queue_request(REQ_UNUSED, VAL_W'($urandom_range(0, 16'hFFFF)),
                        COORD_W'($urandom_range(0, 12'hFFF)),
                        COORD_W'($urandom_range(0, 12'hFFF)),
                        VAL_W'($urandom_range(0, 16'hFFFF)));
        end else begin
          clears_left--;
          queue_request(REQ_CLEAR, VAL_W'($urandom_range(0, 16'hFFFF)),
                        COORD_W'($urandom_range(0, 12'hFFF)),
                        COORD_W'($urandom_range(0, 12'hFFF)),
                        VAL_W'($urandom_range(0, 16'hFFFF)));
        end
      end
      // sender holds off here until every result is back
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run bound; each clear sweeps every bin, so leave room for several
  initial begin : watchdog
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
